@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the checkers of this block.
// Both sample on the rising edge of clock; the first is muted while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DPP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`define DPP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

@@ rtl/core/dpp_pkg.sv @@
`default_nettype none

package dpp_pkg;

   // Operand and accumulator geometry.
   localparam int HALF_W     = 64;
   localparam int WORD_W     = 2 * HALF_W;
   localparam int DIGIT_W    = 32;
   localparam int NUM_DIGITS = WORD_W / DIGIT_W;
   localparam int PROD_W     = 2 * DIGIT_W;
   localparam int NUM_COLS   = 2 * NUM_DIGITS - 1;
   localparam int COL_W      = PROD_W + 2;
   localparam int FULL_W     = 2 * WORD_W;

   // Command codes.
   localparam logic CMD_MAC = 1'b0;
   localparam logic CMD_ADD = 1'b1;

   // One addend on its way to the accumulator.
   typedef struct packed {
      logic              last;
      logic [WORD_W-1:0] addend;
   } dpp_item_type;

   // An addend together with its valid flag.
   typedef struct packed {
      logic         valid;
      dpp_item_type item;
   } dpp_xfer_type;

endpackage

`default_nettype wire

@@ rtl/core/dpp_req_if.sv @@
`default_nettype none

interface dpp_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [63:0] a_lo;
   logic [63:0] a_hi;
   logic [63:0] b_lo;
   logic [63:0] b_hi;
   logic        last;

   modport source (output valid, command, a_lo, a_hi, b_lo, b_hi, last, input ready);
   modport sink (input valid, command, a_lo, a_hi, b_lo, b_hi, last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dpp_rsp_if.sv @@
`default_nettype none

interface dpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] sum_lo;
   logic [63:0] sum_hi;

   modport source (output valid, sum_lo, sum_hi, input ready);
   modport sink (input valid, sum_lo, sum_hi, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wide_fixed_point_dot_product.sv @@
// A last transaction passes stage one, stage two, the addend queue and the result register before its result shows.
// Throughput: one transaction per cycle while the queue has room; the 128-bit accumulator add is the loop that sets it.
// The multiply runs as two registered stages (32 by 32 partial products, column sums).
// Reset is synchronous and active high: it clears the accumulator, the queue and all valids.
`default_nettype none

module wide_fixed_point_dot_product import dpp_pkg::*; #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   dpp_req_if.sink     req_ch,
   dpp_rsp_if.source   rsp_ch
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   dpp_xfer_type     push;
   dpp_xfer_type     head;
   logic             pop;
   logic [CNT_W-1:0] queue_count;

   // Multiply pipeline and command decode.
   dpp_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .queue_count (queue_count),
      .push        (push)
   );

   // Addend queue between the pipeline and the accumulator.
   dpp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (queue_count)
   );

   // Accumulator and result register.
   dpp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

@@ rtl/core/dpp_front.sv @@
`default_nettype none

module dpp_front import dpp_pkg::*; #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dpp_req_if.sink                              req_ch,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     queue_count,
   output dpp_xfer_type                         push
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic                 accept;
   logic [SUM_W-1:0]     occupancy;
   logic [WORD_W-1:0]    a_word;
   logic [WORD_W-1:0]    b_word;

   // Stage one: partial products.
   logic                 v1_ff;
   logic                 cmd1_ff;
   logic                 last1_ff;
   logic [WORD_W-1:0]    a1_ff;
   logic [PROD_W-1:0]    prod1_ff [NUM_DIGITS][NUM_DIGITS];
   logic [PROD_W-1:0]    prod1_in [NUM_DIGITS][NUM_DIGITS];

   // Stage two: column sums.
   logic                 v2_ff;
   logic                 cmd2_ff;
   logic                 last2_ff;
   logic [WORD_W-1:0]    a2_ff;
   logic [COL_W-1:0]     col2_ff [NUM_COLS];
   logic [COL_W-1:0]     col2_in [NUM_COLS];

   // Final carry-propagate add.
   logic [FULL_W-1:0]    lo_vec;
   logic [FULL_W-1:0]    mid_vec;
   logic [FULL_W-1:0]    top_vec;
   logic [FULL_W-1:0]    full_prod;

   // Accept only when every item already in flight still has a queue slot.
   assign occupancy    = SUM_W'(queue_count) + SUM_W'(v1_ff) + SUM_W'(v2_ff);
   assign req_ch.ready = (occupancy < SUM_W'(QUEUE_DEPTH));
   assign accept       = req_ch.valid && req_ch.ready;

   assign a_word = {req_ch.a_hi, req_ch.a_lo};
   assign b_word = {req_ch.b_hi, req_ch.b_lo};

   // Sixteen independent 32 by 32 multipliers.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         for (int j = 0; j < NUM_DIGITS; j++) begin
            prod1_in[i][j] = PROD_W'(a_word[i*DIGIT_W +: DIGIT_W])
                           * PROD_W'(b_word[j*DIGIT_W +: DIGIT_W]);
         end
      end
   end

   // Products of equal weight are summed into one column.
   always_comb begin
      for (int k = 0; k < NUM_COLS; k++) begin
         col2_in[k] = '0;
      end
      for (int i = 0; i < NUM_DIGITS; i++) begin
         for (int j = 0; j < NUM_DIGITS; j++) begin
            col2_in[i+j] = col2_in[i+j] + COL_W'(prod1_ff[i][j]);
         end
      end
   end

   // Columns are split into non-overlapping rows so one three-input add finishes the product.
   always_comb begin
      lo_vec  = '0;
      mid_vec = '0;
      top_vec = '0;
      for (int k = 0; k < NUM_COLS; k++) begin
         lo_vec[k*DIGIT_W +: DIGIT_W] = col2_ff[k][DIGIT_W-1:0];
         if (k + 1 < 2 * NUM_DIGITS) begin
            mid_vec[(k+1)*DIGIT_W +: DIGIT_W] = col2_ff[k][PROD_W-1:DIGIT_W];
         end
         if (k + 2 < 2 * NUM_DIGITS) begin
            top_vec[(k+2)*DIGIT_W +: 2] = col2_ff[k][COL_W-1:PROD_W];
         end
      end
      full_prod = lo_vec + mid_vec + top_vec;
   end

   // The command picks the product's upper half or operand a itself.
   assign push.valid       = v2_ff;
   assign push.item.last   = last2_ff;
   assign push.item.addend = (cmd2_ff == CMD_ADD) ? a2_ff : full_prod[FULL_W-1 -: WORD_W];

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      cmd1_ff  <= req_ch.command;
      last1_ff <= req_ch.last;
      a1_ff    <= a_word;
      prod1_ff <= prod1_in;
      cmd2_ff  <= cmd1_ff;
      last2_ff <= last1_ff;
      a2_ff    <= a1_ff;
      col2_ff  <= col2_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/dpp_queue.sv @@
`default_nettype none

module dpp_queue import dpp_pkg::*; #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dpp_xfer_type                      push,
   input  logic                              pop,
   output dpp_xfer_type                      head,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]  count
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   dpp_item_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   // Pointer and fill count updates; pointers wrap after the last entry.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in  = count_ff + CNT_W'(push.valid) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/dpp_back.sv @@
`default_nettype none

module dpp_back import dpp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dpp_xfer_type  head,
   output logic          pop,
   dpp_rsp_if.source     rsp_ch
);

   logic [WORD_W-1:0] acc_ff;
   logic [WORD_W-1:0] acc_in;
   logic [WORD_W-1:0] sum;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [WORD_W-1:0] out_sum_ff;
   logic              load;
   logic              take;

   // A last item waits only while an earlier result is still held and not taken.
   assign pop  = head.valid && (!head.item.last || !out_valid_ff || rsp_ch.ready);
   assign load = pop && head.item.last;
   assign take = out_valid_ff && rsp_ch.ready;
   assign sum  = acc_ff + head.item.addend;

   // Accumulator: wraps, and restarts from zero after each last transaction.
   always_comb begin
      acc_in = acc_ff;
      if (pop) begin
         acc_in = head.item.last ? '0 : sum;
      end
      out_valid_in = load ? 1'b1 : (take ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load) begin
         out_sum_ff <= sum;
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.sum_lo = out_sum_ff[HALF_W-1:0];
   assign rsp_ch.sum_hi = out_sum_ff[WORD_W-1:HALF_W];

endmodule

`default_nettype wire

@@ rtl/core/dpp_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module dpp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_sum_lo,
   input wire logic [63:0] rsp_sum_hi
);

   logic [7:0]   pending_ff;
   logic [7:0]   pending_in;
   logic         rsp_stall;
   logic [127:0] rsp_sum;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_sum   = {rsp_sum_hi, rsp_sum_lo};

   // Count last transactions accepted whose results are not yet taken.
   always_comb begin
      pending_in = pending_ff + 8'(req_valid && req_ready && req_last)
                 - 8'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A result must never appear without a last transaction behind it.
   `DPP_ASSERT(a_no_invented_result, rsp_valid |-> (pending_ff != 8'd0), "orphan result")

   // Reset clears the result valid flag.
   `DPP_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "result valid after reset")

   // A stalled result stays offered.
   `DPP_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid, "result dropped while stalled")

   // A stalled result keeps its value.
   `DPP_ASSERT(a_rsp_stable, rsp_stall |=> $stable(rsp_sum), "result changed while stalled")

endmodule

bind wide_fixed_point_dot_product dpp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_last   (req_ch.last),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_sum_lo (rsp_ch.sum_lo),
   .rsp_sum_hi (rsp_ch.sum_hi)
);

`default_nettype wire
